// File: src/pal_pkg.sv
`timescale 1ns / 1ps

package pal_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int ENTRY_WIDTH_DEF = 32;

	localparam int OP_W     = 3;
	localparam int POS_W    = 5;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int EXT_W    = 64;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND       = 3'd0,
		OP_PREPEND      = 3'd1,
		OP_INSERT_AT    = 3'd2,
		OP_REMOVE_LAST  = 3'd3,
		OP_REMOVE_FIRST = 3'd4,
		OP_REMOVE_AT    = 3'd5,
		OP_READ_AT      = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	// Broadcast to every slot cell: open a hole (ins) or close one (del).
	typedef struct packed {
		logic ins;
		logic del;
	} cell_cmd_t;

endpackage

// File: src/positional_array_list.sv
`timescale 1ns / 1ps

// Bounded ordered list held in a row of DEPTH slot cells between a head and a tail
// index. One word is taken per clock cycle and its result word appears in the output
// register on the next cycle; a new word is taken while that result waits as long as
// the consumer takes it in the same cycle. Every insert or removal moves all affected
// slots at once, each cell copying its neighbor in parallel, so the rate is one word
// per cycle for any position. Reads go through a DEPTH-way select on the cell outputs.
// Slots come out of reset undefined and there is no clearing pass; only slots that
// have been written can be read. Slots below the head are not reused after a remove
// from the front, so the list can report full with fewer than DEPTH entries.
module positional_array_list #(
	parameter int DEPTH       = pal_pkg::DEPTH_DEF,
	parameter int ENTRY_WIDTH = pal_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [pal_pkg::OP_W-1:0]     op,
	input  logic [pal_pkg::POS_W-1:0]    position,
	input  logic [pal_pkg::WORD_W-1:0]   entry_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pal_pkg::STATUS_W-1:0] status,
	output logic [pal_pkg::WORD_W-1:0]   read_value,
	output logic [pal_pkg::COUNT_W-1:0]  entry_count
);

	localparam int IW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = (IW > pal_pkg::POS_W) ? IW : pal_pkg::POS_W;
	localparam logic [IW-1:0] DEPTH_I = IW'(DEPTH);

	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [IW-1:0] head_nxt;
	logic [IW-1:0] tail_nxt;

	logic                         out_valid_q;
	logic [pal_pkg::STATUS_W-1:0] status_q;
	logic [pal_pkg::WORD_W-1:0]   read_value_q;
	logic [pal_pkg::COUNT_W-1:0]  count_q;

	logic accept;
	logic empty;
	logic full;
	logic [CW-1:0] pos_c;
	logic [CW-1:0] head_c;
	logic [CW-1:0] tail_c;
	logic [CW-1:0] ins_pos_c;
	logic [CW-1:0] count_c;

	logic [pal_pkg::STATUS_W-1:0] status_d;
	logic do_ins;
	logic do_del;
	logic do_rd;
	logic tail_dec;
	logic head_inc;

	logic [pal_pkg::EXT_W-1:0]  wr_ext;
	logic [pal_pkg::EXT_W-1:0]  rd_ext;
	logic [ENTRY_WIDTH-1:0]     wr_data;
	logic [ENTRY_WIDTH-1:0]     rd_sel;
	logic [pal_pkg::WORD_W-1:0] read_value_d;
	logic [ENTRY_WIDTH-1:0]     slot_data [DEPTH];

	pal_pkg::cell_cmd_t cmd;
	logic [IW-1:0]      cell_pos;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign empty  = (head_q == tail_q);
	assign full   = (tail_q >= DEPTH_I);
	assign pos_c  = CW'(position);
	assign head_c = CW'(head_q);
	assign tail_c = CW'(tail_q);

	always_comb begin
		unique case (op)
			pal_pkg::OP_APPEND:  ins_pos_c = tail_c;
			pal_pkg::OP_PREPEND: ins_pos_c = head_c;
			default:             ins_pos_c = pos_c;
		endcase
	end

	always_comb begin
		status_d = pal_pkg::ST_OK;
		do_ins   = 1'b0;
		do_del   = 1'b0;
		do_rd    = 1'b0;
		tail_dec = 1'b0;
		head_inc = 1'b0;
		unique case (op)
			pal_pkg::OP_APPEND: begin
				if (full) begin
					status_d = pal_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			pal_pkg::OP_PREPEND, pal_pkg::OP_INSERT_AT: begin
				if (ins_pos_c < head_c || ins_pos_c > tail_c) begin
					status_d = pal_pkg::ST_BADPOS;
				end else if (full) begin
					status_d = pal_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			pal_pkg::OP_REMOVE_LAST: begin
				if (empty) begin
					status_d = pal_pkg::ST_EMPTY;
				end else begin
					tail_dec = 1'b1;
				end
			end
			pal_pkg::OP_REMOVE_FIRST: begin
				if (empty) begin
					status_d = pal_pkg::ST_EMPTY;
				end else begin
					head_inc = 1'b1;
				end
			end
			pal_pkg::OP_REMOVE_AT: begin
				if (empty) begin
					status_d = pal_pkg::ST_EMPTY;
				end else if (pos_c < head_c || pos_c >= tail_c) begin
					status_d = pal_pkg::ST_BADPOS;
				end else begin
					do_del = 1'b1;
				end
			end
			pal_pkg::OP_READ_AT: begin
				if (empty) begin
					status_d = pal_pkg::ST_EMPTY;
				end else if (pos_c < head_c || pos_c >= tail_c) begin
					status_d = pal_pkg::ST_BADPOS;
				end else begin
					do_rd = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		tail_nxt = tail_q;
		head_nxt = head_q;
		if (do_ins) begin
			tail_nxt = tail_q + 1'b1;
		end else if (do_del || tail_dec) begin
			tail_nxt = tail_q - 1'b1;
		end
		if (head_inc) begin
			head_nxt = head_q + 1'b1;
		end
	end

	assign count_c = CW'(tail_nxt) - CW'(head_nxt);

	assign wr_ext  = pal_pkg::EXT_W'(entry_value);
	assign wr_data = wr_ext[ENTRY_WIDTH-1:0];

	// A valid read position is below the tail, hence below DEPTH.
	assign rd_sel       = slot_data[pos_c[AW-1:0]];
	assign rd_ext       = pal_pkg::EXT_W'(rd_sel);
	assign read_value_d = do_rd ? rd_ext[pal_pkg::WORD_W-1:0] : '0;

	assign cmd.ins  = accept && do_ins;
	assign cmd.del  = accept && do_del;
	assign cell_pos = do_ins ? IW'(ins_pos_c) : IW'(pos_c);

	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		logic [ENTRY_WIDTH-1:0] left_w;
		logic [ENTRY_WIDTH-1:0] right_w;

		if (gi == 0) begin : g_first
			assign left_w = wr_data;
		end else begin : g_mid_l
			assign left_w = slot_data[gi-1];
		end

		if (gi == DEPTH - 1) begin : g_last
			assign right_w = slot_data[gi];
		end else begin : g_mid_r
			assign right_w = slot_data[gi+1];
		end

		pal_cell #(
			.IW          (IW),
			.ENTRY_WIDTH (ENTRY_WIDTH),
			.IDX         (gi)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.pos        (cell_pos),
			.tail       (tail_q),
			.wr_data    (wr_data),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (slot_data[gi])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				head_q      <= head_nxt;
				tail_q      <= tail_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= status_d;
			read_value_q <= read_value_d;
			count_q      <= count_c[pal_pkg::COUNT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign entry_count = count_q;

	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q <= tail_q) && (tail_q <= DEPTH_I))
		else $error("head or tail index out of order");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted word produced no result");

	a_full_append: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == pal_pkg::OP_APPEND && full) |=>
		(status_q == pal_pkg::ST_FULL && $stable(tail_q)))
		else $error("append on full list changed state or misreported");

	a_remove_at_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && do_del) |=> (tail_q == $past(tail_q) - 1'b1 && $stable(head_q)))
		else $error("remove at position did not shrink the tail by one");

endmodule

// File: src/pal_cell.sv
`timescale 1ns / 1ps

module pal_cell #(
	parameter int IW          = 5,
	parameter int ENTRY_WIDTH = 32,
	parameter int IDX         = 0
) (
	input  logic                   clk,
	input  pal_pkg::cell_cmd_t     cmd,
	input  logic [IW-1:0]          pos,
	input  logic [IW-1:0]          tail,
	input  logic [ENTRY_WIDTH-1:0] wr_data,
	input  logic [ENTRY_WIDTH-1:0] left_data,
	input  logic [ENTRY_WIDTH-1:0] right_data,
	output logic [ENTRY_WIDTH-1:0] data
);

	localparam logic [IW:0] MY = (IW+1)'(IDX);

	logic [IW:0] pos_x;
	logic [IW:0] tail_x;
	logic        take_wr;
	logic        take_left;
	logic        take_right;
	logic [ENTRY_WIDTH-1:0] data_q;

	assign pos_x  = {1'b0, pos};
	assign tail_x = {1'b0, tail};

	// On insert, cells above the hole up to the old tail take their left neighbor.
	// On removal, cells from the gap to just below the new tail take their right neighbor.
	assign take_wr    = cmd.ins && (MY == pos_x);
	assign take_left  = cmd.ins && (MY > pos_x) && (MY <= tail_x);
	assign take_right = cmd.del && (MY >= pos_x) && ((MY + 1'b1) < tail_x);

	always_ff @(posedge clk) begin
		if (take_wr) begin
			data_q <= wr_data;
		end else if (take_left) begin
			data_q <= left_data;
		end else if (take_right) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;

endmodule

// File: tb/list_response_checker.sv
`timescale 1ns / 1ps

module list_response_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [pal_pkg::OP_W-1:0]     op,
	input  logic [pal_pkg::POS_W-1:0]    position,
	input  logic [pal_pkg::WORD_W-1:0]   entry_value,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [pal_pkg::STATUS_W-1:0] status,
	input  logic [pal_pkg::WORD_W-1:0]   read_value,
	input  logic [pal_pkg::COUNT_W-1:0]  entry_count,
	output int                           fail_count,
	output int                           pending,
	output int                           checked,
	output int                           seen_ok,
	output int                           seen_full,
	output int                           seen_empty,
	output int                           seen_badpos
);
	import pal_pkg::*;

	localparam int DEPTH = DEPTH_DEF;

	typedef struct packed {
		status_t            status;
		logic [WORD_W-1:0]  read_value;
		logic [COUNT_W-1:0] entry_count;
	} list_result_t;

	logic [WORD_W-1:0] shadow_slots [DEPTH];
	int                shadow_head;
	int                shadow_tail;
	list_result_t      expected_q [$];

	// Applies one operation to the shadow list and returns the response it must produce.
	task automatic apply_list_op(input logic [OP_W-1:0] code, input logic [POS_W-1:0] pos_in,
			input logic [WORD_W-1:0] value, output list_result_t res);
		int pos;
		int i;
		bit empty;
		bit full;
		pos = pos_in;
		empty = (shadow_head == shadow_tail);
		full = (shadow_tail >= DEPTH);
		res.status = ST_OK;
		res.read_value = '0;
		case (code)
			OP_APPEND: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					shadow_slots[shadow_tail] = value;
					shadow_tail++;
				end
			end
			OP_PREPEND, OP_INSERT_AT: begin
				if (code == OP_PREPEND)
					pos = shadow_head;
				// The position check takes priority over the full check.
				if (pos < shadow_head || pos > shadow_tail) begin
					res.status = ST_BADPOS;
				end else if (full) begin
					res.status = ST_FULL;
				end else begin
					for (i = shadow_tail; i > pos; i--)
						if (i < DEPTH)
							shadow_slots[i] = shadow_slots[i - 1];
					shadow_slots[pos] = value;
					shadow_tail++;
				end
			end
			OP_REMOVE_LAST: begin
				if (empty)
					res.status = ST_EMPTY;
				else
					shadow_tail--;
			end
			OP_REMOVE_FIRST: begin
				if (empty)
					res.status = ST_EMPTY;
				else
					shadow_head++;
			end
			OP_REMOVE_AT: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else if (pos < shadow_head || pos >= shadow_tail) begin
					res.status = ST_BADPOS;
				end else begin
					for (i = pos; i + 1 < shadow_tail && i + 1 < DEPTH; i++)
						shadow_slots[i] = shadow_slots[i + 1];
					shadow_tail--;
				end
			end
			OP_READ_AT: begin
				if (empty)
					res.status = ST_EMPTY;
				else if (pos < shadow_head || pos >= shadow_tail || pos >= DEPTH)
					res.status = ST_BADPOS;
				else
					res.read_value = shadow_slots[pos];
			end
			default: ;
		endcase
		res.entry_count = COUNT_W'(shadow_tail - shadow_head);
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			shadow_head = 0;
			shadow_tail = 0;
			expected_q.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
			seen_ok = 0;
			seen_full = 0;
			seen_empty = 0;
			seen_badpos = 0;
		end else begin
			// Responses are compared before this edge's request is queued, since a
			// response never belongs to a word taken at the same edge.
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("response with no word outstanding: status %0d count %0d",
						status, entry_count);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					checked++;
					case (want.status)
						ST_OK:     seen_ok++;
						ST_FULL:   seen_full++;
						ST_EMPTY:  seen_empty++;
						ST_BADPOS: seen_badpos++;
						default: ;
					endcase
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						fail_count++;
					end
					if (read_value !== want.read_value) begin
						$error("read_value: expected %h, actual %h", want.read_value,
							read_value);
						fail_count++;
					end
					if (entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, actual %0d", want.entry_count,
							entry_count);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				apply_list_op(op, position, entry_value, want);
				expected_q.push_back(want);
			end
			pending = expected_q.size();
		end
	end

endmodule

// File: tb/positional_array_list_test.sv
`timescale 1ns / 1ps

module positional_array_list_test;
	import pal_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	localparam int LAST_SLOT   = DEPTH_DEF - 1;
	localparam int RANDOM_GOAL = 1850;
	localparam int HOLD_AT     = 600;
	localparam int HOLD_CYCLES = 150;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     op = '0;
	logic [POS_W-1:0]    position = '0;
	logic [WORD_W-1:0]   entry_value = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [WORD_W-1:0]   read_value;
	logic [COUNT_W-1:0]  entry_count;

	int fail_count;
	int pending;
	int checked;
	int seen_ok;
	int seen_full;
	int seen_empty;
	int seen_badpos;

	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int rx_wait = 0;
	int words_sent = 0;

	positional_array_list dut (.*);

	list_response_checker u_checker (.*);

	always #5 clk = ~clk;

	initial begin
		#4ms;
		$display("[positional_array_list] ERROR");
		$finish;
	end

	// Receiver: draws a wait after every word it takes; once it holds off for a long
	// stretch so that the block backs up into its input.
	always @(posedge clk or negedge arst_n) begin
		int gap;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait <= 0;
			hold_done <= 1'b0;
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			if (rx_wait == 1)
				out_ready <= 1'b1;
		end else if (out_valid && out_ready) begin
			gap = no_idle ? 0 : $urandom_range(0, 7);
			if (hold_req && !hold_done) begin
				gap = HOLD_CYCLES;
				hold_done <= 1'b1;
			end
			if (gap != 0) begin
				out_ready <= 1'b0;
				rx_wait <= gap;
			end
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input logic [OP_W-1:0] code, input int pos,
			input logic [WORD_W-1:0] value);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		position <= pos[POS_W-1:0];
		entry_value <= value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	initial begin
		int i;
		int mode;
		int r;
		logic [OP_W-1:0] code;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// On an empty list, removals, reads and an insert past the tail are refused; an unused code changes nothing.
		send_word(OP_REMOVE_LAST, 0, '0);
		send_word(OP_REMOVE_FIRST, 0, '0);
		send_word(OP_READ_AT, 0, '0);
		send_word(OP_REMOVE_AT, 0, '0);
		send_word(OP_INSERT_AT, 1, rand_word());
		send_word(OP_UNUSED, 3, rand_word());
		send_word(OP_INSERT_AT, 0, '0);
		send_word(OP_PREPEND, 0, '1);
		send_word(OP_INSERT_AT, 2, 32'h1234_5678);
		// Fill to all sixteen slots with a mix of inserts.
		for (i = 3; i < DEPTH_DEF; i++) begin
			case (i % 3)
				0:       send_word(OP_APPEND, 0, rand_word());
				1:       send_word(OP_PREPEND, 0, rand_word());
				default: send_word(OP_INSERT_AT, i / 2, rand_word());
			endcase
		end
		send_word(OP_APPEND, 0, rand_word());
		send_word(OP_INSERT_AT, DEPTH_DEF, rand_word());
		send_word(OP_READ_AT, LAST_SLOT, '0);
		send_word(OP_REMOVE_AT, 0, '0);
		// After the head moves up, slot zero is lost for good and a position below
		// the head is refused.
		send_word(OP_REMOVE_FIRST, 0, '0);
		send_word(OP_INSERT_AT, 0, rand_word());
		send_word(OP_PREPEND, 0, rand_word());
		send_word(OP_APPEND, 0, rand_word());

		// Random bursts, each leaning toward growing, shrinking or mixed traffic.
		// Removal from the front is kept rare because the head never comes back.
		while (words_sent < RANDOM_GOAL) begin
			mode = $urandom_range(0, 2);
			no_idle = ($urandom_range(0, 3) == 0);
			if (words_sent >= HOLD_AT && !hold_req) begin
				hold_req = 1'b1;
				no_idle = 1'b1;
			end
			repeat (40) begin
				r = $urandom_range(0, 199);
				if (r == 0) begin
					code = OP_REMOVE_FIRST;
				end else if (r == 1) begin
					code = OP_UNUSED;
				end else begin
					r = $urandom_range(0, 9);
					if (mode == 0)
						r = (r < 7) ? 0 : (r < 9) ? 1 : 2;
					else if (mode == 1)
						r = (r < 2) ? 0 : (r < 8) ? 1 : 2;
					else
						r = (r < 4) ? 0 : (r < 7) ? 1 : 2;
					case (r)
						0: begin
							case ($urandom_range(0, 2))
								0:       code = OP_APPEND;
								1:       code = OP_PREPEND;
								default: code = OP_INSERT_AT;
							endcase
						end
						1:       code = $urandom_range(0, 1) ? OP_REMOVE_LAST : OP_REMOVE_AT;
						default: code = OP_READ_AT;
					endcase
				end
				send_word(code, $urandom_range(0, DEPTH_DEF), rand_word());
			end
		end
		in_valid <= 1'b0;
		no_idle = 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d list words; %0d responses checked", words_sent, checked);
		$display("(ok %0d, full %0d, empty %0d, bad position %0d).",
			seen_ok, seen_full, seen_empty, seen_badpos);
		if (fail_count == 0)
			$display("[positional_array_list] OK");
		else
			$display("[positional_array_list] ERROR");
		$finish;
	end

endmodule
